// ----- rtl/core/kphc_pkg.sv -----
// ----------------------------------------------------------------------------
// kphc_pkg
// shared types and constants of the key press/hold classifier
// ----------------------------------------------------------------------------
package kphc_pkg;

	localparam int KEY_COUNT_DEF = 18;   // keys per frame
	localparam int KEY_BITS      = 18;   // width of the pressed bitmap
	localparam int HOLD_W        = 12;   // hold counter and threshold width
	localparam int STATE_W       = 3;    // classification code width
	localparam int INDEX_W       = 5;    // key index width on the result
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 12;

	localparam logic [HOLD_W-1:0] HOLD_RESET = 12'd100;

	typedef enum logic [STATE_W-1:0] {
		ST_RELEASED = 3'd0,
		ST_FALLING  = 3'd1,
		ST_RISING   = 3'd2,
		ST_SHORT    = 3'd3,
		ST_LONG     = 3'd4
	} key_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_HOLD  = 2'd0,
		REG_RIGHT_HOLD = 2'd1,
		REG_KBD_HOLD   = 2'd2
	} cfg_reg_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture the frame, restart at key 0
		logic rd_en;     // read one key's record
		logic rd_next;   // read the key after the current one
		logic step;      // retire current key: write back, load result
	} kphc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;      // current key is the final one
		logic out_free;  // result register can take a new result
	} kphc_sts_t;

endpackage

// ----- rtl/core/kphc_if.sv -----
// ----------------------------------------------------------------------------
// kphc_frame_if / kphc_result_if
// valid/ready channels for frames and per-key results
// ----------------------------------------------------------------------------
interface kphc_frame_if
	import kphc_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] pressed_keys;

	modport source (output valid, output pressed_keys, input ready);
	modport sink   (input valid, input pressed_keys, output ready);
endinterface

interface kphc_result_if
	import kphc_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] key_index;
	logic [STATE_W-1:0] key_state;
	logic [STATE_W-1:0] previous_state;
	logic               last_of_frame;

	modport source (output valid, output key_index, output key_state,
		output previous_state, output last_of_frame, input ready);
	modport sink   (input valid, input key_index, input key_state,
		input previous_state, input last_of_frame, output ready);
endinterface

// ----- rtl/core/kphc_ctrl.sv -----
// ----------------------------------------------------------------------------
// kphc_ctrl
// sequencer walking the keys of one frame
// ----------------------------------------------------------------------------
module kphc_ctrl
	import kphc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      frame_valid,
	output logic      frame_ready,
	input  kphc_sts_t sts,
	output kphc_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_RUN   = 3'b100
	} ctrl_state_t;

	ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx    = state_q;
		cmd         = '0;
		frame_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				frame_ready = 1'b1;
				if (frame_valid) begin
					cmd.load = 1'b1;
					state_nx = S_FETCH;
				end
			end
			S_FETCH: begin
				cmd.rd_en = 1'b1;
				state_nx  = S_RUN;
			end
			S_RUN: begin
				if (sts.out_free) begin
					cmd.step = 1'b1;
					if (sts.last) begin
						state_nx = S_IDLE;
					end else begin
						// prefetch the next key while retiring this one
						cmd.rd_en   = 1'b1;
						cmd.rd_next = 1'b1;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/kphc_dp.sv -----
// ----------------------------------------------------------------------------
// kphc_dp
// per-key record store, classification logic and result register
// ----------------------------------------------------------------------------
module kphc_dp
	import kphc_pkg::*;
#(
	parameter int KEY_COUNT = KEY_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [KEY_BITS-1:0]   pressed_keys,
	input  kphc_cmd_t             cmd,
	output kphc_sts_t             sts,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [INDEX_W-1:0]    key_index,
	output logic [STATE_W-1:0]    key_state,
	output logic [STATE_W-1:0]    previous_state,
	output logic                  last_of_frame
);

	localparam int IdxW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int RecW = HOLD_W + STATE_W;

	logic [HOLD_W-1:0]   left_hold_q, right_hold_q, kbd_hold_q;
	logic [KEY_BITS-1:0] pressed_q;
	logic [IdxW-1:0]     idx_q;
	logic [RecW-1:0]     mem_q [KEY_COUNT];
	logic [KEY_COUNT-1:0] vld_q;
	logic [RecW-1:0]     rdata_s1;
	logic                rvld_s1;

	logic                result_valid_q;
	logic [INDEX_W-1:0]  key_index_q;
	logic [STATE_W-1:0]  key_state_q;
	logic [STATE_W-1:0]  previous_state_q;
	logic                last_q;

	logic [IdxW-1:0]     rd_addr;
	logic                last_key;
	logic [HOLD_W-1:0]   cnt_cur;
	logic [STATE_W-1:0]  st_cur;
	logic [KEY_BITS-1:0] shifted;
	logic                pressed;
	logic [HOLD_W-1:0]   thr_raw, thr;
	logic [HOLD_W:0]     cnt_inc;
	logic [HOLD_W-1:0]   cnt_nx;
	key_state_t          st_nx;
	logic [INDEX_W+IdxW-1:0] idx_ext;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_hold_q  <= HOLD_RESET;
			right_hold_q <= HOLD_RESET;
			kbd_hold_q   <= HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_HOLD:  left_hold_q  <= cfg_data[HOLD_W-1:0];
				REG_RIGHT_HOLD: right_hold_q <= cfg_data[HOLD_W-1:0];
				REG_KBD_HOLD:   kbd_hold_q   <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign last_key = (idx_q == IdxW'(KEY_COUNT - 1));
	assign rd_addr  = cmd.rd_next ? IdxW'(idx_q + 1'b1) : idx_q;

	// frame capture and key counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.step && !last_key) begin
			idx_q <= IdxW'(idx_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pressed_q <= pressed_keys;
		end
	end

	// record store: one read, one write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			mem_q[idx_q] <= {cnt_nx, st_nx};
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (cmd.step) begin
				vld_q[idx_q] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rvld_s1 <= vld_q[rd_addr];
			end
		end
	end

	// never-written record reads as counter zero, released
	assign cnt_cur = rvld_s1 ? rdata_s1[RecW-1:STATE_W] : '0;
	assign st_cur  = rvld_s1 ? rdata_s1[STATE_W-1:0] : ST_RELEASED;

	// keys beyond the bitmap are never pressed
	assign shifted = pressed_q >> idx_q;
	assign pressed = shifted[0];

	always_comb begin
		if (idx_q == '0) begin
			thr_raw = left_hold_q;
		end else if (idx_q == IdxW'(1)) begin
			thr_raw = right_hold_q;
		end else begin
			thr_raw = kbd_hold_q;
		end
	end
	assign thr     = (thr_raw == '0) ? HOLD_W'(1) : thr_raw;
	assign cnt_inc = {1'b0, cnt_cur} + (HOLD_W+1)'(1);

	always_comb begin
		if (!pressed) begin
			st_nx  = (cnt_cur != '0) ? ST_FALLING : ST_RELEASED;
			cnt_nx = '0;
		end else if (cnt_inc == (HOLD_W+1)'(1)) begin
			st_nx  = ST_RISING;
			cnt_nx = HOLD_W'(1);
		end else if (cnt_inc >= {1'b0, thr}) begin
			st_nx  = ST_LONG;
			cnt_nx = thr;
		end else begin
			st_nx  = ST_SHORT;
			cnt_nx = cnt_inc[HOLD_W-1:0];
		end
	end

	assign idx_ext = {{INDEX_W{1'b0}}, idx_q};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.step) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			key_index_q      <= idx_ext[INDEX_W-1:0];
			key_state_q      <= st_nx;
			previous_state_q <= st_cur;
			last_q           <= last_key;
		end
	end

	assign sts.last      = last_key;
	assign sts.out_free  = !result_valid_q || result_ready;

	assign result_valid   = result_valid_q;
	assign key_index      = key_index_q;
	assign key_state      = key_state_q;
	assign previous_state = previous_state_q;
	assign last_of_frame  = last_q;

endmodule

// ----- rtl/core/key_press_hold_classifier.sv -----
// ----------------------------------------------------------------------------
// key_press_hold_classifier
// per-key press, hold and release classification of input frames
// ----------------------------------------------------------------------------
// Each frame transaction carries a pressed bitmap (bit 0 left mouse button,
// bit 1 right mouse button, then keyboard keys). The block walks the keys in
// order and returns one result transaction per key with the new and the
// previous classification (released, falling edge, rising edge, short press,
// long press); the last result of a frame carries last_of_frame. Once a frame
// is accepted, the first per-key record read is made, then one key is retired
// per cycle while the result side takes results, the record read being
// prefetched one key ahead; the next frame is accepted once the last key is
// retired. The user must have the three hold thresholds written through the
// cfg port only while the block is idle; the block itself does not enforce
// it. A zero threshold behaves as one. Records come out of reset as released
// with a zero hold count, held by per-key valid bits, so no clearing pass.
// ----------------------------------------------------------------------------
module key_press_hold_classifier
	import kphc_pkg::*;
#(
	parameter int KEY_COUNT = KEY_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	kphc_frame_if.sink            frame,
	kphc_result_if.source         result
);

	// command and status between sequencer and datapath
	kphc_cmd_t cmd;
	kphc_sts_t sts;

	// sequencer: idle, first fetch, then one key per cycle while results are taken
	kphc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame.valid),
		.frame_ready (frame.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	// datapath: thresholds, record memory, classifier, result register
	kphc_dp #(
		.KEY_COUNT (KEY_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pressed_keys   (frame.pressed_keys),
		.cmd            (cmd),
		.sts            (sts),
		.result_valid   (result.valid),
		.result_ready   (result.ready),
		.key_index      (result.key_index),
		.key_state      (result.key_state),
		.previous_state (result.previous_state),
		.last_of_frame  (result.last_of_frame)
	);

endmodule

// ----- rtl/core/kphc_checker.sv -----
// ----------------------------------------------------------------------------
// kphc_checker
// port-level checks of the key press/hold classifier
// ----------------------------------------------------------------------------
module kphc_checker
	import kphc_pkg::*;
#(
	parameter int KEY_COUNT = KEY_COUNT_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               frame_valid,
	input logic               frame_ready,
	input logic               result_valid,
	input logic               result_ready,
	input logic [INDEX_W-1:0] key_index,
	input logic [STATE_W-1:0] key_state,
	input logic [STATE_W-1:0] previous_state,
	input logic               last_of_frame
);

	// a frame is being walked right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_ready |=> !frame_ready)
		else $error("frame accepted while previous frame in progress");

	// end of frame marks the final key
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_of_frame |-> key_index == INDEX_W'(KEY_COUNT - 1))
		else $error("last_of_frame on wrong key");

	// rising edge only follows a released or falling key
	a_rising_prev: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && key_state == ST_RISING |->
			previous_state == ST_RELEASED || previous_state == ST_FALLING)
		else $error("rising edge after held state");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(key_index)
			&& $stable(key_state) && $stable(previous_state))
		else $error("result changed while stalled");

endmodule

bind key_press_hold_classifier kphc_checker #(
	.KEY_COUNT (KEY_COUNT)
) u_kphc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.frame_valid    (frame.valid),
	.frame_ready    (frame.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.key_index      (result.key_index),
	.key_state      (result.key_state),
	.previous_state (result.previous_state),
	.last_of_frame  (result.last_of_frame)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the key press/hold classifier
// ----------------------------------------------------------------------------
// Frames are driven on the frame channel and every per-key result is checked
// against a classifier model kept in the bench. A short table of directed
// frames comes first (reset state, all keys held and released, zero and one
// thresholds, threshold lowered while keys are held), then random phases of
// held-key sequences under random thresholds, random idling on both sides, a
// long result-side stall, a drain pause, and finally a long hold that drives
// the hold counters into saturation at the threshold.
// ----------------------------------------------------------------------------
module tb;
	import kphc_pkg::*;

	localparam int KEY_COUNT = KEY_COUNT_DEF;
	localparam logic [KEY_BITS-1:0] ALL_KEYS = {KEY_BITS{1'b1}};
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;   // no register behind it
	localparam int RX_STALL_CYCLES = 300;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_FRAMES = 22;
	localparam int SATURATE_FRAMES = 24;
	localparam logic [HOLD_W-1:0] SATURATE_TICKS = 12'd20;
	localparam int MAX_REPORTS = 10;

	typedef enum logic {ROW_FRAME, ROW_SET_TICKS} row_kind_t;

	// typed expectation for a whole frame: every key gets the same codes
	typedef struct packed {
		logic       fixed;
		key_state_t st;
		key_state_t prev;
	} frame_tag_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [KEY_BITS-1:0] keys;
		frame_tag_t          tag;
		logic [HOLD_W-1:0]   left;
		logic [HOLD_W-1:0]   right;
		logic [HOLD_W-1:0]   kbd;
	} dir_row_t;

	typedef struct packed {
		logic [INDEX_W-1:0] key_index;
		key_state_t         key_state;
		key_state_t         previous_state;
		logic               last_of_frame;
	} key_result_t;

	localparam frame_tag_t NO_TAG = '{1'b0, ST_RELEASED, ST_RELEASED};

	// directed frames and threshold changes, walked in order
	localparam dir_row_t DIRECTED [26] = '{
		// reset thresholds of 100
		'{ROW_FRAME, 18'h00000, '{1'b1, ST_RELEASED, ST_RELEASED}, 12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, ALL_KEYS,  '{1'b1, ST_RISING,   ST_RELEASED}, 12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, ALL_KEYS,  '{1'b1, ST_SHORT,    ST_RISING},   12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, ALL_KEYS,  '{1'b1, ST_SHORT,    ST_SHORT},    12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, 18'h00000, '{1'b1, ST_FALLING,  ST_SHORT},    12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, 18'h00000, '{1'b1, ST_RELEASED, ST_FALLING},  12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, 18'h2AAAA, NO_TAG, 12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, 18'h15555, NO_TAG, 12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, 18'h00001, NO_TAG, 12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, 18'h20000, NO_TAG, 12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, 18'h00000, NO_TAG, 12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, 18'h00000, NO_TAG, 12'd0, 12'd0, 12'd0},
		// zero acts as one on the left button, one on the right, two on keys
		'{ROW_SET_TICKS, 18'h0, NO_TAG, 12'd0, 12'd1, 12'd2},
		'{ROW_FRAME, ALL_KEYS,  '{1'b1, ST_RISING,   ST_RELEASED}, 12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, ALL_KEYS,  '{1'b1, ST_LONG,     ST_RISING},   12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, ALL_KEYS,  '{1'b1, ST_LONG,     ST_LONG},     12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, 18'h00000, '{1'b1, ST_FALLING,  ST_LONG},     12'd0, 12'd0, 12'd0},
		// hold a while, then change the thresholds under the held keys (left and keys lowered, right raised)
		'{ROW_SET_TICKS, 18'h0, NO_TAG, 12'd100, 12'd100, 12'd100},
		'{ROW_FRAME, ALL_KEYS,  NO_TAG, 12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, ALL_KEYS,  NO_TAG, 12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, ALL_KEYS,  NO_TAG, 12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, ALL_KEYS,  NO_TAG, 12'd0, 12'd0, 12'd0},
		'{ROW_SET_TICKS, 18'h0, NO_TAG, 12'd3, 12'd4095, 12'd2},
		'{ROW_FRAME, ALL_KEYS,  NO_TAG, 12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, ALL_KEYS,  NO_TAG, 12'd0, 12'd0, 12'd0},
		'{ROW_FRAME, 18'h00000, NO_TAG, 12'd0, 12'd0, 12'd0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	kphc_frame_if  frame_ch ();
	kphc_result_if result_ch ();

	key_press_hold_classifier #(
		.KEY_COUNT (KEY_COUNT)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frame     (frame_ch.sink),
		.result    (result_ch.source)
	);

	// classifier model state, mirrored from the block
	logic [HOLD_W-1:0] hold_cnt   [KEY_COUNT];
	key_state_t        key_status [KEY_COUNT];
	logic [HOLD_W-1:0] ticks_left;
	logic [HOLD_W-1:0] ticks_right;
	logic [HOLD_W-1:0] ticks_kbd;

	key_result_t pending_results [$];   // per-key results still to come
	frame_tag_t  frame_tags [$];        // one tag per offered frame
	int          errors;
	bit          idle_en;               // random idling on both sides
	bit          rx_stall_req;          // ask the receiver for a long hold-off

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// model of the block: classify every key of one accepted frame
	// ------------------------------------------------------------------------
	function automatic void classify_frame(input logic [KEY_BITS-1:0] keys,
		input frame_tag_t tag);
		logic [HOLD_W:0]   cnt;      // one bit wider so the increment never wraps
		logic [HOLD_W-1:0] thr;
		key_state_t        st;
		key_result_t       r;
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (!keys[k]) begin
				// released: falling edge only if it was held last frame
				st  = (hold_cnt[k] != '0) ? ST_FALLING : ST_RELEASED;
				cnt = '0;
			end else begin
				thr = (k == 0) ? ticks_left : (k == 1) ? ticks_right : ticks_kbd;
				if (thr == '0)
					thr = HOLD_W'(1);
				cnt = {1'b0, hold_cnt[k]} + 1'b1;
				if (cnt == 1) begin
					st = ST_RISING;
				end else if (cnt >= {1'b0, thr}) begin
					// long press, counter parks at the threshold
					st  = ST_LONG;
					cnt = {1'b0, thr};
				end else begin
					st = ST_SHORT;
				end
			end
			r.key_index      = INDEX_W'(k);
			r.key_state      = tag.fixed ? tag.st : st;
			r.previous_state = tag.fixed ? tag.prev : key_status[k];
			r.last_of_frame  = (k == KEY_COUNT - 1);
			hold_cnt[k]   = cnt[HOLD_W-1:0];
			key_status[k] = st;
			pending_results.push_back(r);
		end
	endfunction

	task automatic note_error(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------------
	// monitor: register writes, accepted frames and accepted results, all
	// sampled at the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		key_result_t got;
		key_result_t want;
		frame_tag_t  tag;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LEFT_HOLD:  ticks_left  = cfg_data;
					REG_RIGHT_HOLD: ticks_right = cfg_data;
					REG_KBD_HOLD:   ticks_kbd   = cfg_data;
					default: ;   // out-of-range index, write dropped
				endcase
			end
			if (frame_ch.valid && frame_ch.ready) begin
				tag = (frame_tags.size() != 0) ? frame_tags.pop_front() : NO_TAG;
				classify_frame(frame_ch.pressed_keys, tag);
			end
			if (result_ch.valid && result_ch.ready) begin
				got.key_index      = result_ch.key_index;
				got.key_state      = key_state_t'(result_ch.key_state);
				got.previous_state = key_state_t'(result_ch.previous_state);
				got.last_of_frame  = result_ch.last_of_frame;
				if (pending_results.size() == 0) begin
					note_error($sformatf("unexpected result transaction: key %0d state %0d",
						got.key_index, got.key_state));
				end else begin
					want = pending_results.pop_front();
					if (got !== want)
						note_error($sformatf({"result mismatch: expected key %0d state %0d ",
							"prev %0d last %0d, got key %0d state %0d prev %0d last %0d"},
							want.key_index, want.key_state, want.previous_state,
							want.last_of_frame, got.key_index, got.key_state,
							got.previous_state, got.last_of_frame));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// result side: short random stalls, or one long hold-off on request
	// ------------------------------------------------------------------------
	initial begin
		int  rx_hold;
		bit  stall;
		bit  long_done;
		rx_hold   = 0;
		long_done = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			stall = 1'b0;
			if (rx_hold > 0) begin
				rx_hold--;
				stall = 1'b1;
			end else if (rx_stall_req && !long_done) begin
				// long hold-off so the block backs up into the frame side
				long_done = 1'b1;
				rx_hold   = RX_STALL_CYCLES - 1;
				stall     = 1'b1;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				rx_hold = $urandom_range(1, 4) - 1;
				stall   = 1'b1;
			end
			result_ch.ready <= !stall;
		end
	end

	// offer one frame and wait for its transaction; valid stays up afterward
	task automatic send_frame(input logic [KEY_BITS-1:0] keys, input frame_tag_t tag);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			frame_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		frame_tags.push_back(tag);
		frame_ch.valid        <= 1'b1;
		frame_ch.pressed_keys <= keys;
		do @(posedge clk); while (!frame_ch.ready);
	endtask

	// stop offering and wait until every expected result has been seen
	task automatic wait_drained();
		frame_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// write the three thresholds, then poke the unused index
	task automatic set_hold_ticks(input logic [HOLD_W-1:0] l, r, kb);
		logic [CFG_DATA_W-1:0] vals [4];
		logic [CFG_IDX_W-1:0]  idxs [4];
		vals = '{l, r, kb, {CFG_DATA_W{1'b1}}};
		idxs = '{REG_LEFT_HOLD, REG_RIGHT_HOLD, REG_KBD_HOLD, REG_NONE};
		for (int i = 0; i < 4; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data  <= vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// thresholds lean small so long presses come quickly
	function automatic logic [HOLD_W-1:0] pick_ticks();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return HOLD_W'(1);
			2:       return {HOLD_W{1'b1}};
			3, 4:    return HOLD_W'($urandom_range(2, 8));
			default: return HOLD_W'($urandom_range(9, 100));
		endcase
	endfunction

	// mostly keep keys held and flip a few, sometimes a fresh bitmap
	function automatic logic [KEY_BITS-1:0] next_keys(input logic [KEY_BITS-1:0] cur);
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 14)
			return cur ^ KEY_BITS'($urandom & $urandom & $urandom);
		else if (pick < 17)
			return cur;
		else if (pick < 19)
			return KEY_BITS'($urandom);
		else
			return (cur == '0) ? ALL_KEYS : '0;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [KEY_BITS-1:0] cur;
		errors       = 0;
		idle_en      = 1'b1;
		rx_stall_req = 1'b0;
		ticks_left   = HOLD_RESET;
		ticks_right  = HOLD_RESET;
		ticks_kbd    = HOLD_RESET;
		for (int k = 0; k < KEY_COUNT; k++) begin
			hold_cnt[k]   = '0;
			key_status[k] = ST_RELEASED;
		end
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = '0;
		cfg_data              = '0;
		frame_ch.valid        = 1'b0;
		frame_ch.pressed_keys = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_SET_TICKS) begin
				wait_drained();
				set_hold_ticks(DIRECTED[i].left, DIRECTED[i].right, DIRECTED[i].kbd);
			end else begin
				send_frame(DIRECTED[i].keys, DIRECTED[i].tag);
			end
		end

		// random phases; phase 1 carries the long result-side hold-off,
		// phase 3 a drain pause in the middle, phase 2 and the last one run without idling
		cur = '0;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drained();
			set_hold_ticks(pick_ticks(), pick_ticks(), pick_ticks());
			idle_en = (ph != 2) && (ph != RANDOM_PHASES - 1);
			if (ph == 1)
				rx_stall_req = 1'b1;
			for (int n = 0; n < PHASE_FRAMES; n++) begin
				if ((ph == 3 && n == PHASE_FRAMES / 2) || $urandom_range(0, 24) == 0)
					wait_drained();
				cur = next_keys(cur);
				send_frame(cur, NO_TAG);
			end
		end

		// hold every key long enough to reach the threshold and stay
		wait_drained();
		set_hold_ticks(SATURATE_TICKS, SATURATE_TICKS, SATURATE_TICKS);
		for (int n = 0; n < SATURATE_FRAMES; n++)
			send_frame(ALL_KEYS, NO_TAG);
		send_frame('0, NO_TAG);

		// drain, then a short quiet tail to catch stray results
		wait_drained();
		repeat (2 * KEY_COUNT + 4) @(posedge clk);
		if (pending_results.size() != 0)
			note_error($sformatf("%0d expected results never arrived",
				pending_results.size()));
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#6_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/kphc_pkg.sv
rtl/core/kphc_if.sv
rtl/core/kphc_ctrl.sv
rtl/core/kphc_dp.sv
rtl/core/key_press_hold_classifier.sv
rtl/core/kphc_checker.sv
tb/sv/tb.sv
